### rtl/core/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// shared codes and types of the circuit path tracker
// ----------------------------------------------------------------------------
`default_nettype none

package cpt_pkg;

  localparam int unsigned DEF_MAX_NODES = 64;
  localparam int unsigned DEF_TAG_BITS  = 16;
  localparam int unsigned CFG_W         = 7;

  // request kinds
  localparam logic [1:0] KIND_ASSIGN = 2'd0;
  localparam logic [1:0] KIND_REWIND = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_RANGE   = 3'd1;
  localparam logic [2:0] ST_TAKEN   = 3'd2;
  localparam logic [2:0] ST_SUBCIRC = 3'd3;
  localparam logic [2:0] ST_PIGEON  = 3'd4;
  localparam logic [2:0] ST_NOVALUE = 3'd5;

  // configuration register indexes
  localparam logic [0:0] REG_NODE_COUNT   = 1'b0;
  localparam logic [0:0] REG_VALUE_OFFSET = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR,
    OP_A_CHK,
    OP_A_RD,
    OP_A_WR1,
    OP_A_WR2,
    OP_R_WR1,
    OP_R_WR2,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic range_bad;
    logic taken_bad;
    logic subcircuit;
    logic undo_empty;
    logic undo_stop;
    logic clr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/cpt_datapath.sv
// ----------------------------------------------------------------------------
// cpt_datapath
// path memories, free-value set, undo log, counters and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_datapath #(
  parameter int unsigned MAX_NODES = cpt_pkg::DEF_MAX_NODES,
  parameter int unsigned TAG_BITS  = cpt_pkg::DEF_TAG_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cpt_pkg::dp_op_e       op_i,
  output cpt_pkg::dp_stat_t          stat_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [0:0]            cfg_addr_i,
  input  wire logic [6:0]            cfg_wdata_i,
  input  wire logic [1:0]            kind_i,
  input  wire logic [5:0]            var_index_i,
  input  wire logic [7:0]            value_i,
  input  wire logic [TAG_BITS-1:0]   save_tag_i,
  output logic                       done_o,
  output logic [2:0]                 status_o,
  output logic                       circuit_closed_o,
  output logic                       prune_valid_o,
  output logic [5:0]                 prune_node_o,
  output logic [7:0]                 prune_value_o,
  output logic                       forced_valid_o,
  output logic [7:0]                 forced_value_o,
  output logic [6:0]                 unfixed_left_o,
  output logic [6:0]                 free_left_o
);
  import cpt_pkg::*;

  localparam int unsigned NB   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned DW   = $clog2(MAX_NODES + 1);
  localparam int unsigned NCAP = (MAX_NODES > 127) ? 127 : MAX_NODES;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [NB-1:0]       node;
    logic [NB-1:0]       target;
    logic [NB-1:0]       head;
    logic [NB-1:0]       tail;
    logic [6:0]          old_len;
    logic [6:0]          old_free;
    logic [6:0]          old_unf;
    logic                merge;
  } undo_t;

  // configuration
  logic [6:0] node_count_q, value_offset_q, n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q   <= 7'd64;
      value_offset_q <= 7'd1;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_NODE_COUNT) begin
        node_count_q <= cfg_wdata_i;
      end else begin
        value_offset_q <= cfg_wdata_i;
      end
    end
  end

  assign n = (node_count_q > 7'(NCAP)) ? 7'(NCAP) : node_count_q;

  // request registers
  logic [1:0]          kind_q;
  logic [5:0]          vi_q;
  logic [7:0]          raw_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [7:0]          jv;
  logic [NB-1:0]       i_idx, j_idx;

  assign jv    = raw_q - {1'b0, value_offset_q};
  assign i_idx = NB'(vi_q);
  assign j_idx = NB'(jv);

  // memories
  logic [NB-1:0] partner_mem [MAX_NODES];
  logic [6:0]    len_mem     [MAX_NODES];
  logic          taken_mem   [MAX_NODES];
  logic          fixed_mem   [MAX_NODES];
  logic [NB-1:0] flist_mem   [MAX_NODES];
  logic [NB-1:0] fpos_mem    [MAX_NODES];
  undo_t         undo_mem    [MAX_NODES];

  logic [NB-1:0] pi_q, pj_q, flist_rd_q, fpos_rd_q;
  logic [6:0]    len_rd_q;
  logic          taken_rd_q, fixed_rd_q;
  undo_t         undo_rd_q;

  // working registers
  logic [NB-1:0] h_q, t_q, pos_q, lastv_q, last_q, clr_idx_q;
  logic [6:0]    lenj_q, sum_q, free_q, unf_q;
  logic          merge_q, ok_q, take_ok_q;
  logic [2:0]    status_q;
  logic [DW-1:0] depth_q;

  logic [NB-1:0] last, fl_ra, len_ra, u_ra;
  logic          h_is_j, subcircuit, range_bad, log_room;

  assign last       = NB'(free_q - 7'd1);
  assign h_is_j     = (h_q == j_idx);
  assign subcircuit = h_is_j && (len_rd_q < n);
  assign range_bad  = ({1'b0, vi_q} >= n) || (raw_q < {1'b0, value_offset_q})
                      || (jv >= {1'b0, n});
  assign log_room   = (depth_q < DW'(MAX_NODES));
  assign u_ra       = NB'(depth_q - DW'(1));
  assign fl_ra      = (op_i == OP_A_CHK) ? last : '0;
  assign len_ra     = (op_i == OP_A_RD) ? pi_q : j_idx;

  assign stat_o.range_bad  = range_bad;
  assign stat_o.taken_bad  = taken_rd_q || fixed_rd_q;
  assign stat_o.subcircuit = subcircuit;
  assign stat_o.undo_empty = (depth_q == '0);
  assign stat_o.undo_stop  = (undo_rd_q.tag <= tag_q);
  assign stat_o.clr_last   = (clr_idx_q == NB'(MAX_NODES - 1));

  // write ports
  logic          p_we, l_we, tk_we, fx_we, fl_we, fp_we, u_we, tk_wd, fx_wd;
  logic [NB-1:0] p_wa, p_wd, l_wa, tk_wa, fx_wa, fl_wa, fl_wd, fp_wa, fp_wd;
  logic [6:0]    l_wd;
  undo_t         u_wd;

  always_comb begin
    p_we = 1'b0;  p_wa = '0;  p_wd = '0;
    l_we = 1'b0;  l_wa = '0;  l_wd = '0;
    tk_we = 1'b0; tk_wa = '0; tk_wd = 1'b0;
    fx_we = 1'b0; fx_wa = '0; fx_wd = 1'b0;
    fl_we = 1'b0; fl_wa = '0; fl_wd = '0;
    fp_we = 1'b0; fp_wa = '0; fp_wd = '0;
    u_we = 1'b0;
    u_wd = '{tag: tag_q, node: i_idx, target: j_idx, head: h_q, tail: t_q,
             old_len: len_rd_q, old_free: free_q, old_unf: unf_q, merge: !h_is_j};
    unique case (op_i)
      OP_CLR: begin
        p_we = 1'b1;  p_wa = clr_idx_q;  p_wd = clr_idx_q;
        l_we = 1'b1;  l_wa = clr_idx_q;  l_wd = 7'd1;
        tk_we = 1'b1; tk_wa = clr_idx_q;
        fx_we = 1'b1; fx_wa = clr_idx_q;
        fl_we = 1'b1; fl_wa = clr_idx_q; fl_wd = clr_idx_q;
        fp_we = 1'b1; fp_wa = clr_idx_q; fp_wd = clr_idx_q;
      end
      OP_A_WR1: begin
        if (!subcircuit) begin
          u_we  = log_room;
          tk_we = 1'b1; tk_wa = j_idx; tk_wd = 1'b1;
          fx_we = 1'b1; fx_wa = i_idx; fx_wd = 1'b1;
          if (take_ok_q) begin
            fl_we = 1'b1; fl_wa = pos_q;   fl_wd = lastv_q;
            fp_we = 1'b1; fp_wa = lastv_q; fp_wd = pos_q;
          end
          if (!h_is_j) begin
            p_we = 1'b1; p_wa = h_q; p_wd = t_q;
            l_we = 1'b1; l_wa = h_q; l_wd = len_rd_q + lenj_q;
          end
        end
      end
      OP_A_WR2: begin
        if (take_ok_q) begin
          fl_we = 1'b1; fl_wa = last_q; fl_wd = j_idx;
          fp_we = 1'b1; fp_wa = j_idx;  fp_wd = last_q;
        end
        if (merge_q) begin
          p_we = 1'b1; p_wa = t_q; p_wd = h_q;
        end
      end
      OP_R_WR1: begin
        tk_we = 1'b1; tk_wa = undo_rd_q.target;
        fx_we = 1'b1; fx_wa = undo_rd_q.node;
        if (undo_rd_q.merge) begin
          p_we = 1'b1; p_wa = undo_rd_q.head; p_wd = undo_rd_q.node;
          l_we = 1'b1; l_wa = undo_rd_q.head; l_wd = undo_rd_q.old_len;
        end
      end
      OP_R_WR2: begin
        if (undo_rd_q.merge) begin
          p_we = 1'b1; p_wa = undo_rd_q.tail; p_wd = undo_rd_q.target;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      partner_mem[p_wa] <= p_wd;
    end
    pi_q <= partner_mem[i_idx];
    pj_q <= partner_mem[j_idx];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      len_mem[l_wa] <= l_wd;
    end
    len_rd_q <= len_mem[len_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tk_we) begin
      taken_mem[tk_wa] <= tk_wd;
    end
    taken_rd_q <= taken_mem[j_idx];
  end

  always_ff @(posedge clk_i) begin
    if (fx_we) begin
      fixed_mem[fx_wa] <= fx_wd;
    end
    fixed_rd_q <= fixed_mem[i_idx];
  end

  always_ff @(posedge clk_i) begin
    if (fl_we) begin
      flist_mem[fl_wa] <= fl_wd;
    end
    flist_rd_q <= flist_mem[fl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fp_we) begin
      fpos_mem[fp_wa] <= fp_wd;
    end
    fpos_rd_q <= fpos_mem[j_idx];
  end

  always_ff @(posedge clk_i) begin
    if (u_we) begin
      undo_mem[NB'(depth_q)] <= u_wd;
    end
    undo_rd_q <= undo_mem[u_ra];
  end

  // result of the request
  logic [2:0] res_status;
  logic       res_closed, res_pv, res_fv, do_last;
  logic [5:0] res_pnode;
  logic [7:0] res_pval, res_fval;

  always_comb begin
    res_status = status_q;
    res_closed = 1'b0;
    res_pv     = 1'b0;
    res_pnode  = '0;
    res_pval   = '0;
    res_fv     = 1'b0;
    res_fval   = '0;
    do_last    = 1'b0;
    if (ok_q) begin
      if (merge_q) begin
        if (unf_q > free_q) begin
          res_status = ST_PIGEON;
        end else begin
          do_last = 1'b1;
          if (sum_q < n) begin
            res_pv    = 1'b1;
            res_pnode = 6'(t_q);
            res_pval  = 8'(h_q) + {1'b0, value_offset_q};
          end
        end
      end else begin
        do_last    = 1'b1;
        res_closed = (unf_q == 7'd0);
      end
      if (do_last && unf_q == 7'd1) begin
        if (free_q == 7'd1) begin
          res_fv   = 1'b1;
          res_fval = 8'(flist_rd_q) + {1'b0, value_offset_q};
        end else if (free_q == 7'd0) begin
          res_status = ST_NOVALUE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
      depth_q   <= '0;
      free_q    <= '0;
      unf_q     <= '0;
      ok_q      <= 1'b0;
      merge_q   <= 1'b0;
      take_ok_q <= 1'b0;
      status_q  <= ST_OK;
      done_o    <= 1'b0;
    end else begin
      done_o    <= (op_i == OP_EMIT);
      clr_idx_q <= (op_i == OP_CLR) ? clr_idx_q + NB'(1) : '0;
      unique case (op_i)
        OP_LOAD: begin
          status_q <= ST_OK;
          ok_q     <= 1'b0;
        end
        OP_CLR: begin
          free_q    <= n;
          unf_q     <= n;
          depth_q   <= '0;
        end
        OP_A_CHK: begin
          if (range_bad) begin
            status_q <= ST_RANGE;
          end
        end
        OP_A_RD: begin
          take_ok_q <= (32'(fpos_rd_q) < 32'(free_q)) && (free_q != 7'd0);
          if (taken_rd_q || fixed_rd_q) begin
            status_q <= ST_TAKEN;
          end
        end
        OP_A_WR1: begin
          if (subcircuit) begin
            status_q <= ST_SUBCIRC;
          end else begin
            ok_q    <= 1'b1;
            merge_q <= !h_is_j;
            if (unf_q != 7'd0) begin
              unf_q <= unf_q - 7'd1;
            end
            if (take_ok_q) begin
              free_q <= free_q - 7'd1;
            end
            if (log_room) begin
              depth_q <= depth_q + DW'(1);
            end
          end
        end
        OP_R_WR1: begin
          free_q <= undo_rd_q.old_free;
          unf_q  <= undo_rd_q.old_unf;
        end
        OP_R_WR2: begin
          depth_q <= depth_q - DW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (op_i == OP_LOAD) begin
      kind_q <= kind_i;
      vi_q   <= var_index_i;
      raw_q  <= value_i;
      tag_q  <= save_tag_i;
    end
    if (op_i == OP_A_RD) begin
      h_q     <= pi_q;
      t_q     <= pj_q;
      lenj_q  <= len_rd_q;
      pos_q   <= fpos_rd_q;
      lastv_q <= flist_rd_q;
      last_q  <= last;
    end
    if (op_i == OP_A_WR1) begin
      sum_q <= len_rd_q + lenj_q;
    end
    if (op_i == OP_EMIT) begin
      status_o         <= (kind_q == KIND_ASSIGN) ? res_status : ST_OK;
      circuit_closed_o <= res_closed;
      prune_valid_o    <= res_pv;
      prune_node_o     <= res_pnode;
      prune_value_o    <= res_pval;
      forced_valid_o   <= res_fv;
      forced_value_o   <= res_fval;
      unfixed_left_o   <= unf_q;
      free_left_o      <= free_q;
    end
  end

endmodule

`default_nettype wire

### rtl/core/cpt_ctrl.sv
// ----------------------------------------------------------------------------
// cpt_ctrl
// sequencer for assign, rewind and clear requests and the clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic [1:0]        kind_i,
  input  wire logic              cfg_clear_i,
  input  wire cpt_pkg::dp_stat_t stat_i,
  output cpt_pkg::dp_op_e        op_o,
  output logic                   busy
);
  import cpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_A1, S_A2, S_A3, S_A4, S_A5, S_R1, S_R2, S_R3, S_EMIT
  } state_e;

  state_e state_q;
  logic   clr_emit_q;

  always_comb begin
    unique case (state_q)
      S_IDLE:  op_o = start ? OP_LOAD : OP_NONE;
      S_CLR:   op_o = cfg_clear_i ? OP_NONE : OP_CLR;  // restart sweep on rewrite
      S_A1:    op_o = OP_A_CHK;
      S_A2:    op_o = OP_A_RD;
      S_A3:    op_o = OP_A_WR1;
      S_A4:    op_o = OP_A_WR2;
      S_R2:    op_o = stat_i.undo_stop ? OP_NONE : OP_R_WR1;
      S_R3:    op_o = OP_R_WR2;
      S_EMIT:  op_o = OP_EMIT;
      default: op_o = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      busy       <= 1'b1;
      clr_emit_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            priority if (kind_i == KIND_ASSIGN) begin
              state_q <= S_A1;
            end else if (kind_i == KIND_REWIND) begin
              state_q <= S_R1;
            end else if (kind_i == KIND_CLEAR) begin
              state_q    <= S_CLR;
              clr_emit_q <= 1'b1;
            end else begin
              state_q <= S_EMIT;
            end
          end else if (cfg_clear_i) begin
            busy       <= 1'b1;
            state_q    <= S_CLR;
            clr_emit_q <= 1'b0;
          end
        end
        S_CLR: begin
          if (!cfg_clear_i && stat_i.clr_last) begin
            state_q <= clr_emit_q ? S_EMIT : S_IDLE;
            busy    <= clr_emit_q;
          end
        end
        S_A1: state_q <= stat_i.range_bad ? S_EMIT : S_A2;
        S_A2: state_q <= stat_i.taken_bad ? S_EMIT : S_A3;
        S_A3: state_q <= stat_i.subcircuit ? S_EMIT : S_A4;
        S_A4: state_q <= S_A5;
        S_A5: state_q <= S_EMIT;
        S_R1: state_q <= stat_i.undo_empty ? S_EMIT : S_R2;
        S_R2: state_q <= stat_i.undo_stop ? S_EMIT : S_R3;
        S_R3: state_q <= S_R1;
        S_EMIT: begin
          state_q <= S_IDLE;
          busy    <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy    <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/circuit_path_tracker.sv
// ----------------------------------------------------------------------------
// circuit_path_tracker
// successor-edge tracker for a hamiltonian circuit constraint
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  request  | start, busy             | kind_i, var_index_i, value_i, save_tag_i
//  result   | done_o (one-cycle)      | status_o .. free_left_o
//  config   | cfg_we_i                | cfg_addr_i, cfg_wdata_i
//
//  assign: check, read, first write, second write, a wait state, then result;
//  a request rejected at check, read or first write goes straight to result
//  rewind: pops undo entries via the undo memory read port until the log runs
//  empty or an entry's tag is at most the request's; clear: the clearing sweep
//  over all MAX_NODES entries, then the result; the sweep also runs, busy high,
//  after reset or node_count writes when idle; results have no back-pressure
// ----------------------------------------------------------------------------
`default_nettype none

module circuit_path_tracker #(
  parameter int unsigned MAX_NODES = cpt_pkg::DEF_MAX_NODES,
  parameter int unsigned TAG_BITS  = cpt_pkg::DEF_TAG_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          kind_i,
  input  wire logic [5:0]          var_index_i,
  input  wire logic [7:0]          value_i,
  input  wire logic [TAG_BITS-1:0] save_tag_i,
  input  wire logic                cfg_we_i,
  input  wire logic [0:0]          cfg_addr_i,
  input  wire logic [6:0]          cfg_wdata_i,
  output logic                     done_o,
  output logic [2:0]               status_o,
  output logic                     circuit_closed_o,
  output logic                     prune_valid_o,
  output logic [5:0]               prune_node_o,
  output logic [7:0]               prune_value_o,
  output logic                     forced_valid_o,
  output logic [7:0]               forced_value_o,
  output logic [6:0]               unfixed_left_o,
  output logic [6:0]               free_left_o
);
  import cpt_pkg::*;

  dp_op_e   op;
  dp_stat_t stat;
  logic     cfg_clear;

  assign cfg_clear = cfg_we_i && (cfg_addr_i == REG_NODE_COUNT);

  cpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .kind_i      (kind_i),
    .cfg_clear_i (cfg_clear),
    .stat_i      (stat),
    .op_o        (op),
    .busy        (busy)
  );

  cpt_datapath #(
    .MAX_NODES (MAX_NODES),
    .TAG_BITS  (TAG_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .kind_i           (kind_i),
    .var_index_i      (var_index_i),
    .value_i          (value_i),
    .save_tag_i       (save_tag_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .circuit_closed_o (circuit_closed_o),
    .prune_valid_o    (prune_valid_o),
    .prune_node_o     (prune_node_o),
    .prune_value_o    (prune_value_o),
    .forced_valid_o   (forced_valid_o),
    .forced_value_o   (forced_value_o),
    .unfixed_left_o   (unfixed_left_o),
    .free_left_o      (free_left_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request accepted without going busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= ST_NOVALUE)) else $error("undefined status code");

  a_prune_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && prune_valid_o) |-> (status_o == ST_OK || status_o == ST_NOVALUE))
    else $error("prune reported with a rejecting status");

endmodule

`default_nettype wire

### sim/circuit_path_tracker_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circuit_path_tracker_check
// watches the request, config and result channels of the path tracker, keeps
// its own copy of the successor-edge state and compares every result
// ----------------------------------------------------------------------------
module circuit_path_tracker_check (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  kind_i,
  input  wire logic [5:0]  var_index_i,
  input  wire logic [7:0]  value_i,
  input  wire logic [15:0] save_tag_i,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_addr_i,
  input  wire logic [6:0]  cfg_wdata_i,
  input  wire logic        done_o,
  input  wire logic [2:0]  status_o,
  input  wire logic        circuit_closed_o,
  input  wire logic        prune_valid_o,
  input  wire logic [5:0]  prune_node_o,
  input  wire logic [7:0]  prune_value_o,
  input  wire logic        forced_valid_o,
  input  wire logic [7:0]  forced_value_o,
  input  wire logic [6:0]  unfixed_left_o,
  input  wire logic [6:0]  free_left_o,
  output int               errors_o,
  output int               pending_o
);
  import cpt_pkg::*;

  localparam int NODES = 64;
  localparam logic [6:0] NO_PRED = 7'h7f;

  typedef struct packed {
    logic [2:0] status;
    logic       closed;
    logic       pv;
    logic [5:0] pnode;
    logic [7:0] pval;
    logic       fv;
    logic [7:0] fval;
    logic [6:0] unfixed;
    logic [6:0] free;
  } outcome_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [5:0]  node, target, head, tail;
    logic [6:0]  old_len, old_free, old_unfixed;
    logic        merge;
  } undo_t;

  logic [6:0] node_count, value_offset;
  logic [5:0] partner[NODES];
  logic [6:0] plen[NODES];
  logic [6:0] pred[NODES];
  logic [5:0] free_list[NODES];
  logic [5:0] free_pos[NODES];
  int unsigned free_cnt, unfixed_cnt, depth;
  undo_t undo_log[NODES];
  outcome_t expected_q[$];
  int errors;

  assign errors_o  = errors;
  assign pending_o = expected_q.size();

  function automatic int unsigned active_nodes();
    return (node_count > NODES) ? NODES : node_count;
  endfunction

  function automatic void clear_paths();
    for (int k = 0; k < NODES; k++) begin
      partner[k]   = k[5:0];
      plen[k]      = 7'd1;
      pred[k]      = NO_PRED;
      free_list[k] = k[5:0];
      free_pos[k]  = k[5:0];
    end
    free_cnt    = active_nodes();
    unfixed_cnt = active_nodes();
    depth       = 0;
  endfunction

  function automatic void take_target(int unsigned v);
    int unsigned pos, last, lastv;
    pos = free_pos[v];
    if (pos >= free_cnt || free_cnt == 0) return;
    last  = free_cnt - 1;
    lastv = free_list[last];
    free_list[pos]  = lastv[5:0];
    free_list[last] = v[5:0];
    free_pos[lastv] = pos[5:0];
    free_pos[v]     = last[5:0];
    free_cnt--;
  endfunction

  function automatic void log_edge(logic [15:0] tag, int unsigned i, j, h, t, logic merge);
    if (depth >= NODES) return;
    undo_log[depth] = '{tag: tag, node: i[5:0], target: j[5:0], head: h[5:0],
                        tail: t[5:0], old_len: plen[h], old_free: free_cnt[6:0],
                        old_unfixed: unfixed_cnt[6:0], merge: merge};
    depth++;
  endfunction

  function automatic void undo_past_tag(logic [15:0] target);
    undo_t e;
    while (depth > 0 && undo_log[depth-1].tag > target) begin
      e = undo_log[depth-1];
      pred[e.target] = NO_PRED;
      free_cnt    = e.old_free;
      unfixed_cnt = e.old_unfixed;
      if (e.merge) begin
        partner[e.head] = e.node;
        partner[e.tail] = e.target;
        plen[e.head]    = e.old_len;
      end
      depth--;
    end
  endfunction

  // single-variable-left checks
  function automatic logic [2:0] last_var_check(inout outcome_t r);
    if (unfixed_cnt == 1) begin
      if (free_cnt == 1) begin
        r.fv   = 1'b1;
        r.fval = 8'(free_list[0]) + {1'b0, value_offset};
      end else if (free_cnt == 0) begin
        return ST_NOVALUE;
      end
    end
    return ST_OK;
  endfunction

  function automatic outcome_t predict_request(logic [1:0] kind, logic [5:0] vi,
                                               logic [7:0] raw, logic [15:0] tag);
    outcome_t r;
    int unsigned n, i, j, h, t;
    logic fixed;
    r = '0;
    n = active_nodes();
    i = vi;
    if (kind == KIND_ASSIGN) begin
      if (i >= n || raw < value_offset || raw - value_offset >= n) begin
        r.status = ST_RANGE;
      end else begin
        j = raw - value_offset;
        fixed = 1'b0;
        for (int k = 0; k < n; k++) if (pred[k] == i) fixed = 1'b1;
        if (pred[j] != NO_PRED || fixed) begin
          r.status = ST_TAKEN;
        end else begin
          h = partner[i];
          t = partner[j];
          if (h == j) begin
            if (plen[h] < n) begin
              r.status = ST_SUBCIRC;
            end else begin
              log_edge(tag, i, j, h, t, 1'b0);
              pred[j] = i[6:0];
              take_target(j);
              if (unfixed_cnt > 0) unfixed_cnt--;
              r.status = last_var_check(r);
              if (unfixed_cnt == 0) r.closed = 1'b1;
            end
          end else begin
            log_edge(tag, i, j, h, t, 1'b1);
            partner[h] = t[5:0];
            partner[t] = h[5:0];
            plen[h] = plen[h] + plen[j];
            pred[j] = i[6:0];
            take_target(j);
            if (unfixed_cnt > 0) unfixed_cnt--;
            if (unfixed_cnt > free_cnt) begin
              r.status = ST_PIGEON;
            end else begin
              if (plen[h] < n) begin
                r.pv    = 1'b1;
                r.pnode = t[5:0];
                r.pval  = 8'(h + value_offset);
              end
              r.status = last_var_check(r);
            end
          end
        end
      end
    end else if (kind == KIND_REWIND) begin
      undo_past_tag(tag);
    end else if (kind == KIND_CLEAR) begin
      clear_paths();
    end
    r.unfixed = unfixed_cnt[6:0];
    r.free    = free_cnt[6:0];
    return r;
  endfunction

  task automatic report(string field, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t w;
    if (!rst_ni) begin
      node_count   = 7'd64;
      value_offset = 7'd1;
      clear_paths();
      expected_q.delete();
    end else begin
      if (done_o) begin
        if (expected_q.size() == 0) begin
          report("unexpected_result", 1, 0);
        end else begin
          w = expected_q.pop_front();
          if (status_o !== w.status)         report("status", status_o, w.status);
          if (circuit_closed_o !== w.closed) report("closed", circuit_closed_o, w.closed);
          if (prune_valid_o !== w.pv)        report("prune_valid", prune_valid_o, w.pv);
          if (prune_node_o !== w.pnode)      report("prune_node", prune_node_o, w.pnode);
          if (prune_value_o !== w.pval)      report("prune_value", prune_value_o, w.pval);
          if (forced_valid_o !== w.fv)       report("forced_valid", forced_valid_o, w.fv);
          if (forced_value_o !== w.fval)     report("forced_value", forced_value_o, w.fval);
          if (unfixed_left_o !== w.unfixed)  report("unfixed_left", unfixed_left_o, w.unfixed);
          if (free_left_o !== w.free)        report("free_left", free_left_o, w.free);
        end
      end
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_NODE_COUNT) begin
          node_count = cfg_wdata_i;
          clear_paths();
        end else begin
          value_offset = cfg_wdata_i;
        end
      end
      if (start && !busy)
        expected_q.insert(expected_q.size(),
                          predict_request(kind_i, var_index_i, value_i, save_tag_i));
    end
  end

  initial errors = 0;

endmodule

### sim/circuit_path_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circuit_path_tracker_test
// drives directed and random edge, rewind and clear requests into the path
// tracker over several node counts and offsets; the checker judges results
// ----------------------------------------------------------------------------
module circuit_path_tracker_test;
  import cpt_pkg::*;

  localparam int LIMIT = 2_000_000;
  localparam logic [1:0] KIND_NOP = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind_i = '0;
  logic [5:0] var_index_i = '0;
  logic [7:0] value_i = '0;
  logic [15:0] save_tag_i = '0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_addr_i = '0;
  logic [6:0] cfg_wdata_i = '0;
  logic done_o, circuit_closed_o, prune_valid_o, forced_valid_o;
  logic [2:0] status_o;
  logic [5:0] prune_node_o;
  logic [7:0] prune_value_o, forced_value_o;
  logic [6:0] unfixed_left_o, free_left_o;
  int errors, pending, cycles, sent;
  logic quiet;
  int unsigned cur_nodes, cur_offset;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  circuit_path_tracker uut (.*);
  circuit_path_tracker_check chk (.*, .errors_o(errors), .pending_o(pending));

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i); while (busy || pending != 0);
    @(posedge clk_i);
  endtask

  task automatic send_request(logic [1:0] kind, logic [5:0] vi, logic [7:0] val,
                              logic [15:0] tag);
    int gap;
    logic ok;
    gap = (!quiet && $urandom_range(0, 99) < 30) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    kind_i <= kind;
    var_index_i <= vi;
    value_i <= val;
    save_tag_i <= tag;
    do begin
      @(negedge clk_i);
      ok = !busy;
      @(posedge clk_i);
    end while (!ok);
    sent++;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [6:0] data);
    start <= 1'b0;
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_NODE_COUNT) cur_nodes = data;
    else cur_offset = data;
    wait_idle();
  endtask

  function automatic logic [7:0] raw_of(int unsigned node);
    return 8'(node + cur_offset);
  endfunction

  // one well-formed circuit, assigned in random order, with wrong edges and
  // rewinds mixed in
  task automatic build_circuit();
    int unsigned n, base, tag, a, b, tmp;
    int unsigned order[64], succ[64];
    n = (cur_nodes > 64) ? 64 : cur_nodes;
    base = $urandom_range(0, 65000);
    tag = base;
    send_request(KIND_CLEAR, 6'($urandom), 8'($urandom), 16'($urandom));
    if (n == 0) return;
    for (int k = 0; k < n; k++) order[k] = k;
    for (int k = n - 1; k > 0; k--) begin
      b = $urandom_range(0, k);
      tmp = order[k]; order[k] = order[b]; order[b] = tmp;
    end
    for (int k = 0; k < n; k++) succ[order[k]] = order[(k + 1) % n];
    for (int k = n - 1; k > 0; k--) begin
      b = $urandom_range(0, k);
      tmp = order[k]; order[k] = order[b]; order[b] = tmp;
    end
    for (int k = 0; k < n; k++) begin
      a = order[k];
      tag = tag + $urandom_range(0, 8);
      if ($urandom_range(0, 99) < 8) begin
        send_request(KIND_ASSIGN, 6'($urandom_range(0, n - 1)),
                     raw_of($urandom_range(0, n - 1)), 16'(tag));
      end else if ($urandom_range(0, 99) < 4) begin
        send_request(KIND_NOP, 6'($urandom), 8'($urandom), 16'($urandom));
      end
      send_request(KIND_ASSIGN, a[5:0], raw_of(succ[a]), 16'(tag));
      if ($urandom_range(0, 99) < 5) begin
        send_request(KIND_REWIND, 6'($urandom), 8'($urandom),
                     16'($urandom_range(base, tag)));
        break;
      end
    end
  endtask

  initial begin
    int unsigned nodes_set[8] = '{64, 4, 12, 1, 0, 64, 33, 2};
    int unsigned offs_set[8] = '{1, 0, 127, 5, 1, 127, 0, 1};
    cycles = 0;
    sent = 0;
    quiet = 1'b1;
    cur_nodes = 64;
    cur_offset = 1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // directed: range, taken, subcircuit, rewind, no-op and clear
    send_request(KIND_ASSIGN, 6'd63, 8'd0, 16'hffff);
    send_request(KIND_ASSIGN, 6'd0, 8'd255, 16'h0000);
    send_request(KIND_ASSIGN, 6'd0, 8'd2, 16'd1);
    send_request(KIND_ASSIGN, 6'd5, 8'd2, 16'd2);
    send_request(KIND_ASSIGN, 6'd0, 8'd9, 16'd3);
    send_request(KIND_ASSIGN, 6'd1, 8'd1, 16'd4);
    send_request(KIND_ASSIGN, 6'd63, 8'd64, 16'hffff);
    send_request(KIND_REWIND, 6'd0, 8'd0, 16'd1);
    send_request(KIND_NOP, 6'h3f, 8'hff, 16'hffff);
    send_request(KIND_REWIND, 6'd0, 8'd0, 16'd0);
    send_request(KIND_CLEAR, 6'd0, 8'd0, 16'd0);
    // two nodes: forced value, then full closure
    write_reg(REG_VALUE_OFFSET, 7'd127);
    write_reg(REG_NODE_COUNT, 7'd2);
    send_request(KIND_ASSIGN, 6'd0, 8'd126, 16'd1);
    send_request(KIND_ASSIGN, 6'd2, 8'd128, 16'd1);
    send_request(KIND_ASSIGN, 6'd0, 8'd128, 16'd1);
    send_request(KIND_ASSIGN, 6'd1, 8'd127, 16'd2);
    send_request(KIND_ASSIGN, 6'd1, 8'd128, 16'd3);
    send_request(KIND_REWIND, 6'd0, 8'd0, 16'd1);
    send_request(KIND_ASSIGN, 6'd1, 8'd127, 16'd5);
    write_reg(REG_NODE_COUNT, 7'd0);
    send_request(KIND_ASSIGN, 6'd0, 8'd127, 16'd0);

    quiet = 1'b0;
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_NODE_COUNT, nodes_set[p][6:0]);
      write_reg(REG_VALUE_OFFSET, offs_set[p][6:0]);
      while (sent < 24 + (p + 1) * 229) begin
        quiet = (p == 3);
        if ($urandom_range(0, 99) < 12)
          send_request(2'($urandom), 6'($urandom), 8'($urandom), 16'($urandom));
        else
          build_circuit();
      end
    end

    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
